// ===== rtl/thtemp_pkg.sv =====
package thtemp_pkg;

	// Reference resistor of the divider, in ohms.
	localparam int unsigned REF_OHMS = 10000;

	// Resistance table: Q.8 ohms, descending, one entry per 5 degrees from -15.
	localparam int unsigned STORED_ENTRIES = 34;
	localparam int unsigned RES_W = 27;
	localparam int unsigned TBL_IW = 6;
	localparam logic [RES_W-1:0] RES_Q8 [STORED_ENTRIES] = '{
		27'd86233856, 27'd65565645, 27'd50287411, 27'd38890854, 27'd30316083,
		27'd23811046, 27'd18837171, 27'd15005338, 27'd12032000, 27'd9708877,
		27'd7881754, 27'd6435610, 27'd5284045, 27'd4361677, 27'd3618765,
		27'd3017165, 27'd2527462, 27'd2126874, 27'd1797606, 27'd1525683,
		27'd1300147, 27'd1112294, 27'd955136, 27'd823168, 27'd711936,
		27'd617779, 27'd537856, 27'd469734, 27'd411469, 27'd361523,
		27'd318515, 27'd281421, 27'd249293, 27'd221414
	};

	// Fraction of the interpolation: 16 fraction bits, up to and including one.
	localparam int unsigned FRAC_W = 17;

	localparam int unsigned TEMP_W = 11;
	localparam logic signed [TEMP_W-1:0] TEMP_COLD = -11'sd99;
	localparam logic signed [TEMP_W-1:0] TEMP_HOT = 11'sd999;
	localparam logic signed [31:0] TEMP_BASE_Q16 = 32'sd983040;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_COLD = 2'd1,
		ST_HOT = 2'd2
	} status_t;

endpackage

// ===== rtl/thtemp_sample_if.sv =====
interface thtemp_sample_if;
	logic valid;
	logic ready;
	logic [15:0] adc_sample;

	modport source (output valid, output adc_sample, input ready);
	modport sink (input valid, input adc_sample, output ready);
endinterface

// ===== rtl/thtemp_result_if.sv =====
interface thtemp_result_if
	import thtemp_pkg::*;
;
	logic valid;
	logic ready;
	logic signed [TEMP_W-1:0] temperature;
	logic [1:0] range_status;

	modport source (output valid, output temperature, output range_status, input ready);
	modport sink (input valid, input temperature, input range_status, output ready);
endinterface

// ===== rtl/thermistor_adc_to_temperature.sv =====
// Thermistor converter sample to temperature.
// The sample channel takes one raw count per request; the result channel gives one
// temperature (whole degrees, truncated toward zero) and a range status per request,
// in order. Status 1 means cold (-99), status 2 means hot (999).
// The path is one pipeline: an entry register, a restoring divider that resolves one
// quotient bit per stage for the resistance (ADC_BITS+22 stages), a table compare
// stage, a select stage, a 17-stage divider for the interpolation fraction and an
// output register. One request can enter every cycle and one result leaves every cycle
// while the receiver does not hold ready low.
// When the receiver holds ready low while a result is shown, the whole pipeline
// stops and sample ready falls in the same cycle; nothing is dropped or repeated.
// Reset clears every valid bit; no result is shown until a new request passes through.
module thermistor_adc_to_temperature
	import thtemp_pkg::*;
#(
	parameter int unsigned TABLE_ENTRIES = 34,
	parameter int unsigned ADC_BITS = 12
) (
	input logic clk,
	input logic arst_n,
	thtemp_sample_if.sink sample,
	thtemp_result_if.source result
);

	localparam int unsigned USED = (TABLE_ENTRIES < STORED_ENTRIES) ?
		TABLE_ENTRIES : STORED_ENTRIES;
	localparam int unsigned IW = $clog2(USED + 1);
	localparam int unsigned N1 = ADC_BITS + 22;
	localparam int unsigned D1 = ADC_BITS + 1;

	typedef struct packed {
		status_t st;
		logic [N1-1:0] nq;
		logic [D1-1:0] rem;
		logic [D1-1:0] den;
	} d1_t;

	typedef struct packed {
		status_t st;
		logic [IW-1:0] idx;
		logic [FRAC_W-1:0] nq;
		logic [RES_W-1:0] rem;
		logic [RES_W-1:0] den;
	} d2_t;

	logic en;
	logic [D1-1:0] full;

	d1_t d1_s [N1+1];
	logic v1_s [N1+1];

	status_t c_st_s;
	logic [N1-1:0] c_r_s;
	logic [USED-1:0] c_lt_s;
	logic c_v_s;

	d2_t d2_s [FRAC_W+1];
	logic v2_s [FRAC_W+1];

	logic signed [TEMP_W-1:0] o_temp_s;
	status_t o_st_s;
	logic o_v_s;

	// The whole pipeline advances together unless the last result is held.
	assign en = !o_v_s || result.ready;
	assign sample.ready = en;
	assign full = D1'(1) << ADC_BITS;

	// Entry stage: classify the sample and set up the resistance division.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s[0] <= 1'b0;
		end else if (en) begin
			v1_s[0] <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (sample.adc_sample == 16'd0) begin
				d1_s[0].st <= ST_HOT;
			end else if (17'(sample.adc_sample) >= 17'(full)) begin
				d1_s[0].st <= ST_COLD;
			end else begin
				d1_s[0].st <= ST_OK;
			end
			d1_s[0].nq <= (N1'(sample.adc_sample[ADC_BITS-1:0]) * N1'(REF_OHMS)) << 8;
			d1_s[0].rem <= '0;
			d1_s[0].den <= full - D1'(sample.adc_sample[ADC_BITS-1:0]);
		end
	end

	// Resistance divider: one quotient bit per stage.
	for (genvar k = 0; k < N1; k++) begin : g_div1
		logic [D1:0] trial;
		logic ge;

		always_comb begin
			trial = {d1_s[k].rem, d1_s[k].nq[N1-1]};
			ge = trial >= {1'b0, d1_s[k].den};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v1_s[k+1] <= 1'b0;
			end else if (en) begin
				v1_s[k+1] <= v1_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				d1_s[k+1].st <= d1_s[k].st;
				d1_s[k+1].den <= d1_s[k].den;
				d1_s[k+1].nq <= {d1_s[k].nq[N1-2:0], ge};
				d1_s[k+1].rem <= ge ? D1'(trial - {1'b0, d1_s[k].den}) : D1'(trial);
			end
		end
	end

	// Compare stage: the resistance against every table entry in parallel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_v_s <= 1'b0;
		end else if (en) begin
			c_v_s <= v1_s[N1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_st_s <= d1_s[N1].st;
			c_r_s <= d1_s[N1].nq;
			for (int k = 0; k < USED; k++) begin
				c_lt_s[k] <= d1_s[N1].nq < N1'(RES_Q8[k]);
			end
		end
	end

	// Select stage: pick the bracketing entries and set up the fraction division.
	logic [IW-1:0] sel_idx;
	logic [TBL_IW-1:0] hi_sel;
	logic [TBL_IW-1:0] lo_sel;
	logic [RES_W-1:0] hi_res;
	logic [RES_W-1:0] lo_res;
	logic [RES_W-1:0] diff;
	status_t sel_st;

	always_comb begin
		sel_idx = '0;
		for (int k = 0; k < USED; k++) begin
			if (c_lt_s[k]) begin
				sel_idx = IW'(k + 1);
			end
		end
		hi_sel = (sel_idx == '0) ? '0 : TBL_IW'(sel_idx - IW'(1));
		lo_sel = (sel_idx >= IW'(USED)) ? TBL_IW'(USED - 1) : TBL_IW'(sel_idx);
		hi_res = RES_Q8[hi_sel];
		lo_res = RES_Q8[lo_sel];
		diff = RES_W'(N1'(hi_res) - c_r_s);
		priority if (c_st_s != ST_OK) begin
			sel_st = c_st_s;
		end else if (sel_idx == '0) begin
			sel_st = ST_COLD;
		end else if (sel_idx >= IW'(USED)) begin
			sel_st = ST_HOT;
		end else begin
			sel_st = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_s[0] <= 1'b0;
		end else if (en) begin
			v2_s[0] <= c_v_s;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d2_s[0].st <= sel_st;
			d2_s[0].idx <= sel_idx;
			d2_s[0].rem <= diff >> 1;
			d2_s[0].nq <= {diff[0], 16'd0};
			d2_s[0].den <= hi_res - lo_res;
		end
	end

	// Fraction divider: one quotient bit per stage.
	for (genvar k = 0; k < FRAC_W; k++) begin : g_div2
		logic [RES_W:0] trial;
		logic ge;

		always_comb begin
			trial = {d2_s[k].rem, d2_s[k].nq[FRAC_W-1]};
			ge = trial >= {1'b0, d2_s[k].den};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v2_s[k+1] <= 1'b0;
			end else if (en) begin
				v2_s[k+1] <= v2_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				d2_s[k+1].st <= d2_s[k].st;
				d2_s[k+1].idx <= d2_s[k].idx;
				d2_s[k+1].den <= d2_s[k].den;
				d2_s[k+1].nq <= {d2_s[k].nq[FRAC_W-2:0], ge};
				d2_s[k+1].rem <= ge ? RES_W'(trial - {1'b0, d2_s[k].den}) :
					RES_W'(trial);
			end
		end
	end

	// Output stage: scale to degrees and truncate toward zero.
	logic signed [31:0] pos_q16;
	logic signed [31:0] temp_q16;
	logic signed [31:0] temp_deg;
	logic signed [TEMP_W-1:0] out_temp;

	always_comb begin
		pos_q16 = ((32'(d2_s[FRAC_W].idx) - 32'sd1) <<< 16) + 32'(d2_s[FRAC_W].nq);
		temp_q16 = pos_q16 * 32'sd5 - TEMP_BASE_Q16;
		temp_deg = temp_q16 >>> 16;
		if (temp_q16 < 0 && temp_q16[15:0] != 16'd0) begin
			temp_deg = temp_deg + 32'sd1;
		end
		unique case (d2_s[FRAC_W].st)
			ST_COLD: out_temp = TEMP_COLD;
			ST_HOT: out_temp = TEMP_HOT;
			default: out_temp = TEMP_W'(temp_deg);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_v_s <= 1'b0;
		end else if (en) begin
			o_v_s <= v2_s[FRAC_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			o_temp_s <= out_temp;
			o_st_s <= d2_s[FRAC_W].st;
		end
	end

	assign result.valid = o_v_s;
	assign result.temperature = o_temp_s;
	assign result.range_status = o_st_s;

`ifndef SYNTHESIS
	// The input side takes a request exactly when the pipeline may advance.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		sample.ready == (!result.valid || result.ready))
		else $error("sample ready does not follow the output stall");

	// A cold status always carries the cold marker.
	a_cold: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.range_status == ST_COLD) |-> result.temperature == TEMP_COLD)
		else $error("cold status without cold marker");

	// A hot status always carries the hot marker.
	a_hot: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.range_status == ST_HOT) |-> result.temperature == TEMP_HOT)
		else $error("hot status without hot marker");

	// An interpolated temperature lies inside the span of the table.
	a_span: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.range_status == ST_OK) |->
		(result.temperature >= -11'sd15 && result.temperature <= 11'sd150))
		else $error("interpolated temperature outside the table span");
`endif

endmodule
